[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the biphase packet decoder.
// No dependencies; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

[hw/rtl/bppd_pkg.sv]
// Types, constants and the header length function of the biphase packet decoder.
// No dependencies.
`default_nettype none

package bppd_pkg;

  localparam int INTERVAL_WIDTH_DEFAULT = 16;
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_GLITCH_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SILENCE_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_BIT_MIN  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FULL_BIT_MAX  = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_BIT_MIN  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_BIT_MAX  = 3'd5;

  // configuration reset values
  localparam logic [CFG_WIDTH-1:0] GLITCH_LIMIT_RST  = 16'd3;
  localparam logic [CFG_WIDTH-1:0] SILENCE_LIMIT_RST = 16'd80;
  localparam logic [CFG_WIDTH-1:0] FULL_BIT_MIN_RST  = 16'd40;
  localparam logic [CFG_WIDTH-1:0] FULL_BIT_MAX_RST  = 16'd60;
  localparam logic [CFG_WIDTH-1:0] HALF_BIT_MIN_RST  = 16'd18;
  localparam logic [CFG_WIDTH-1:0] HALF_BIT_MAX_RST  = 16'd32;

  // byte framing positions
  localparam logic [3:0] PARITY_POS = 4'd9;
  localparam logic [3:0] STOP_POS   = 4'd10;

  // seven preamble ones needed before the header start bit
  localparam logic [6:0] PREAMBLE_FULL = 7'h7F;

  // result status codes
  localparam logic [1:0] ST_BYTE   = 2'd0;
  localparam logic [1:0] ST_CK_OK  = 2'd1;
  localparam logic [1:0] ST_CK_BAD = 2'd2;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_HEADER   = 3'd1,
    PH_MESSAGE  = 3'd2,
    PH_CHECKSUM = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_pos;
    logic [6:0]  pre_ones;
    logic [7:0]  shift;
    logic        parity;
    logic [4:0]  bytes_exp;
    logic [4:0]  bytes_rcv;
    logic [7:0]  run_xor;
  } dec_t;

  localparam dec_t DEC_CLEAR = '{
    phase:     PH_PREAMBLE,
    bit_pos:   4'd0,
    pre_ones:  7'd0,
    shift:     8'd0,
    parity:    1'b1,
    bytes_exp: 5'd0,
    bytes_rcv: 5'd0,
    run_xor:   8'd0
  };

  // header thresholds and offsets of the message length code
  localparam logic [7:0] HDR_ONE_LIM     = 8'h20;
  localparam logic [7:0] HDR_SIXTEEN_LIM = 8'h80;
  localparam logic [7:0] HDR_EIGHT_LIM   = 8'hE0;
  localparam logic [5:0] EIGHTH_OFS      = 6'd8;
  localparam logic [5:0] QUARTER_OFS     = 6'd36;

  // number of message bytes that a header announces (1..27)
  function automatic logic [4:0] msg_length(input logic [7:0] hdr);
    logic [5:0] len;
    begin
      if (hdr < HDR_ONE_LIM) begin
        len = 6'd1;
      end else if (hdr < HDR_SIXTEEN_LIM) begin
        len = {2'b00, hdr[7:4]};
      end else if (hdr < HDR_EIGHT_LIM) begin
        len = {1'b0, hdr[7:3]} - EIGHTH_OFS;
      end else begin
        len = hdr[7:2] - QUARTER_OFS;
      end
      return len[4:0];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/biphase_power_packet_decoder_top.sv]
// Biphase power packet decoder: edge intervals in, packet bytes out.
// Depends on bppd_pkg and assert_macros.svh.
//
// Usage:
//   s_* channel: one beat per line edge interval; s_tdata holds interval_ticks
//     (bits above INTERVAL_WIDTH are ignored).
//   m_* channel: one beat per completed packet byte; m_tdata holds data_byte
//     and byte_index, m_tuser holds the status (byte, checksum good/bad).
//   cfg_* channel: register writes, always ready; write only while idle.
// Timing:
//   An accepted interval waits in the input register; as it advances it is
//   classified, updates the decoder and, when it completes a byte, loads the
//   result register that drives m_tvalid.
//   One interval per cycle is sustained while no result waits; the single
//   decode pass between the input and result registers sets that figure.
// Stall:
//   While a result waits (m_tvalid high, m_tready low) the input register
//   holds and no interval is decoded, byte or not; s_tready stays high until
//   the input register fills, then drops until the result drains.
// Reset (rst, synchronous): registers return to their default limits, the
//   decoder to the preamble phase, both beat registers empty.
`default_nettype none

`include "assert_macros.svh"

module biphase_power_packet_decoder_top
  import bppd_pkg::*;
#(
  parameter int INTERVAL_WIDTH = INTERVAL_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input stream
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((INTERVAL_WIDTH+7)/8)*8-1:0]   s_tdata,   // [IW-1:0] interval_ticks
  // output stream
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [15:0]                                m_tdata,   // [7:0] data_byte,
                                                                // [12:8] byte_index
  output logic [1:0]                                 m_tuser,   // [1:0] status
  // configuration writes
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0]            cfg_index,
  input  wire logic [CFG_WIDTH-1:0]                  cfg_data
);

  localparam int CMP_W = (INTERVAL_WIDTH > CFG_WIDTH) ? INTERVAL_WIDTH : CFG_WIDTH;

  // ---------------- configuration registers ----------------
  logic [CFG_WIDTH-1:0] glitch_limit, silence_limit;
  logic [CFG_WIDTH-1:0] full_bit_min, full_bit_max, half_bit_min, half_bit_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_limit  <= GLITCH_LIMIT_RST;
      silence_limit <= SILENCE_LIMIT_RST;
      full_bit_min  <= FULL_BIT_MIN_RST;
      full_bit_max  <= FULL_BIT_MAX_RST;
      half_bit_min  <= HALF_BIT_MIN_RST;
      half_bit_max  <= HALF_BIT_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GLITCH_LIMIT:  glitch_limit  <= cfg_data;
        REG_SILENCE_LIMIT: silence_limit <= cfg_data;
        REG_FULL_BIT_MIN:  full_bit_min  <= cfg_data;
        REG_FULL_BIT_MAX:  full_bit_max  <= cfg_data;
        REG_HALF_BIT_MIN:  half_bit_min  <= cfg_data;
        REG_HALF_BIT_MAX:  half_bit_max  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                      in_valid;
  logic [INTERVAL_WIDTH-1:0] in_t;
  logic                      out_free;
  logic                      advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_t <= s_tdata[INTERVAL_WIDTH-1:0];
    end
  end

  // ---------------- decoder state ----------------
  logic [INTERVAL_WIDTH-1:0] interval_now, interval_now_next;
  logic [INTERVAL_WIDTH-1:0] interval_before, interval_before_next;
  dec_t                      dec, dec_next;

  // ---------------- interval classification ----------------
  logic             take;        // interval above the glitch limit
  logic             cls_clear;   // silence or preamble out of range
  logic             bit_vld;
  logic             bit_val;
  logic [CMP_W-1:0] t_x, bef_x;
  logic [INTERVAL_WIDTH-1:0] cand_now, cand_before;
  logic             now_half, bef_half;

  always_comb begin
    t_x       = CMP_W'(in_t);
    bef_x     = CMP_W'(interval_now);
    take      = advance && (t_x > CMP_W'(glitch_limit));
    now_half  = (t_x > CMP_W'(half_bit_min)) && (t_x < CMP_W'(half_bit_max));
    bef_half  = (bef_x > CMP_W'(half_bit_min)) && (bef_x < CMP_W'(half_bit_max));
    cls_clear = 1'b0;
    bit_vld   = 1'b0;
    bit_val   = 1'b0;
    cand_now    = in_t;
    cand_before = interval_now;
    if (t_x > CMP_W'(silence_limit)) begin
      cls_clear = 1'b1;
    end else if ((dec.phase == PH_PREAMBLE) &&
                 ((t_x > CMP_W'(full_bit_max)) || (t_x < CMP_W'(half_bit_min)))) begin
      cls_clear = 1'b1;
    end else if ((t_x > CMP_W'(full_bit_min)) && (t_x < CMP_W'(full_bit_max))) begin
      bit_vld = 1'b1;
    end else if (now_half && bef_half) begin
      // two half intervals in a row form a one; the pair is consumed
      bit_vld     = 1'b1;
      bit_val     = 1'b1;
      cand_now    = '0;
      cand_before = '0;
    end
  end

  // ---------------- next decoder state ----------------
  logic       wipe;
  logic [2:0] data_idx;
  logic [4:0] rcv_inc;

  assign data_idx = 3'(dec.bit_pos - 4'd1);
  assign rcv_inc  = dec.bytes_rcv + 5'd1;

  always_comb begin
    dec_next             = dec;
    interval_now_next    = interval_now;
    interval_before_next = interval_before;
    wipe                 = 1'b0;
    if (take) begin
      interval_now_next    = cand_now;
      interval_before_next = cand_before;
      if (cls_clear) begin
        wipe = 1'b1;
      end else if (bit_vld) begin
        unique case (dec.phase)
          PH_PREAMBLE: begin
            if (!bit_val) begin
              if (dec.pre_ones == PREAMBLE_FULL) begin
                dec_next.phase   = PH_HEADER;
                dec_next.bit_pos = 4'd1;
                dec_next.shift   = 8'd0;
                dec_next.parity  = 1'b1;
              end else begin
                dec_next.pre_ones = 7'd0;
              end
            end else begin
              dec_next.pre_ones = {dec.pre_ones[5:0], 1'b1};
            end
          end
          PH_HEADER, PH_MESSAGE, PH_CHECKSUM: begin
            if (dec.bit_pos == 4'd0) begin
              if (bit_val) wipe = 1'b1;
              else dec_next.bit_pos = 4'd1;
            end else if (dec.bit_pos < PARITY_POS) begin
              if (bit_val) begin
                dec_next.shift[data_idx] = 1'b1;
                dec_next.parity          = !dec.parity;
              end
              dec_next.bit_pos = dec.bit_pos + 4'd1;
            end else if (dec.bit_pos == PARITY_POS) begin
              if (bit_val != dec.parity) wipe = 1'b1;
              else dec_next.bit_pos = STOP_POS;
            end else if (!bit_val) begin
              wipe = 1'b1;
            end else begin
              // stop bit: byte complete
              dec_next.shift   = 8'd0;
              dec_next.parity  = 1'b1;
              dec_next.bit_pos = 4'd0;
              unique case (dec.phase)
                PH_HEADER: begin
                  dec_next.bytes_exp = msg_length(dec.shift);
                  dec_next.bytes_rcv = 5'd0;
                  dec_next.run_xor   = dec.shift;
                  dec_next.phase     = PH_MESSAGE;
                end
                PH_MESSAGE: begin
                  dec_next.run_xor   = dec.run_xor ^ dec.shift;
                  dec_next.bytes_rcv = rcv_inc;
                  if (rcv_inc >= dec.bytes_exp) dec_next.phase = PH_CHECKSUM;
                end
                default: dec_next.phase = PH_DONE;
              endcase
            end
          end
          // done phase and unused codes: the next bit restarts the search
          default: wipe = 1'b1;
        endcase
      end
    end
    if (wipe) begin
      dec_next             = DEC_CLEAR;
      interval_now_next    = '0;
      interval_before_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec             <= DEC_CLEAR;
      interval_now    <= '0;
      interval_before <= '0;
    end else begin
      dec             <= dec_next;
      interval_now    <= interval_now_next;
      interval_before <= interval_before_next;
    end
  end

  // ---------------- result ----------------
  logic       emit;
  logic [4:0] res_index;
  logic [1:0] res_status;

  always_comb begin
    emit = take && !cls_clear && bit_vld && bit_val && (dec.bit_pos >= STOP_POS) &&
           ((dec.phase == PH_HEADER) || (dec.phase == PH_MESSAGE) ||
            (dec.phase == PH_CHECKSUM));
    res_index  = 5'd0;
    res_status = ST_BYTE;
    unique case (dec.phase)
      PH_MESSAGE: res_index = rcv_inc;
      PH_CHECKSUM: begin
        res_index  = dec.bytes_exp + 5'd1;
        res_status = (dec.run_xor == dec.shift) ? ST_CK_OK : ST_CK_BAD;
      end
      default: res_index = 5'd0;
    endcase
  end

  logic [7:0] out_byte;
  logic [4:0] out_index;
  logic [1:0] out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_byte   <= dec.shift;
      out_index  <= res_index;
      out_status <= res_status;
    end
  end

  assign m_tdata = {3'b000, out_index, out_byte};
  assign m_tuser = out_status;

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_in_hold, clk, rst, (in_valid && !advance) |=> (in_valid && $stable(in_t)), "input beat lost while stalled")
  `ASSERT_NEVER(a_status_code, clk, rst, m_tvalid && (m_tuser != ST_BYTE) && (m_tuser != ST_CK_OK) && (m_tuser != ST_CK_BAD), "illegal status code")
  `ASSERT_CLK(a_ck_done, clk, rst, (advance && emit && (res_status != ST_BYTE)) |=> (dec.phase == PH_DONE), "checksum byte did not end packet")
  `ASSERT_CLK(a_header_first, clk, rst, (advance && emit && (dec.phase == PH_HEADER)) |=> (m_tdata[12:8] == 5'd0), "header index not zero")
  `ASSERT_NEVER(a_bitpos_range, clk, rst, dec.bit_pos > STOP_POS, "bit position past stop bit")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for biphase_power_packet_decoder_top: biphase line
// intervals in, packet bytes checked against an in-bench decoder model.
// Depends on bppd_pkg and the decoder RTL.

module tb_top;
  import bppd_pkg::*;

  localparam int STALL_LIMIT   = 4000;  // cycles with no beat on any channel
  localparam int SEG_ITEMS     = 30;    // intervals per random segment
  localparam int MIN_BYTES     = 48;    // random traffic runs until this many came
  localparam int PIPE_SETTLE   = 6;     // lets the input and result registers empty
  localparam int REPORT_LIMIT  = 10;

  typedef enum {BIT_ZERO, BIT_ONE, BIT_NONE} line_bit_t;
  typedef enum {FAULT_NONE, FAULT_START, FAULT_PARITY, FAULT_STOP} frame_fault_t;
  typedef enum {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic [7:0] data;
    logic [4:0] idx;
    logic [1:0] st;
  } pkt_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;

  biphase_power_packet_decoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model: limits, interval history and framing state
  // ---------------------------------------------------------------------------
  logic [15:0] lim_glitch, lim_silence, full_lo, full_hi, half_lo, half_hi;
  logic [15:0] ivl_cur, ivl_prev;
  phase_t      phase;
  logic [3:0]  bit_pos;
  logic [7:0]  pre_ones;
  logic [7:0]  shift_reg;
  logic        par;
  logic [4:0]  n_exp, n_rcv;
  logic [7:0]  xor_acc;

  pkt_byte_t   byte_q[$];     // bytes the decoder still owes
  pkt_byte_t   want;
  int          err_count = 0;
  int          bytes_checked = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  function automatic void reset_decoder_state();
    ivl_cur   = '0;
    ivl_prev  = '0;
    phase     = PH_PREAMBLE;
    bit_pos   = '0;
    pre_ones  = '0;
    shift_reg = '0;
    par       = 1'b1;
    n_exp     = '0;
    n_rcv     = '0;
    xor_acc   = '0;
  endfunction

  function automatic bit in_half_window(input logic [15:0] t);
    return t > half_lo && t < half_hi;
  endfunction

  function automatic int announced_length(input logic [7:0] hdr);
    if (hdr < HDR_ONE_LIM) return 1;
    if (hdr < HDR_SIXTEEN_LIM) return int'(hdr) / 16;
    if (hdr < HDR_EIGHT_LIM) return int'(hdr) / 8 - 8;
    return int'(hdr) / 4 - 36;
  endfunction

  function automatic line_bit_t classify_intervals();
    if (ivl_cur > lim_silence) begin
      reset_decoder_state();
      return BIT_NONE;
    end
    // in the preamble anything outside the half..full span means no carrier
    if (phase == PH_PREAMBLE && (ivl_cur > full_hi || ivl_cur < half_lo)) begin
      reset_decoder_state();
      return BIT_NONE;
    end
    if (ivl_cur > full_lo && ivl_cur < full_hi) return BIT_ZERO;
    if (in_half_window(ivl_cur) && in_half_window(ivl_prev)) begin
      ivl_cur  = '0;
      ivl_prev = '0;
      return BIT_ONE;
    end
    return BIT_NONE;
  endfunction

  // start, eight data bits LSB first, odd parity, stop; true on a good stop
  function automatic bit take_frame_bit(input line_bit_t b);
    logic [3:0] k;
    if (bit_pos == 4'd0) begin
      if (b != BIT_ZERO) begin
        reset_decoder_state();
        return 1'b0;
      end
      bit_pos = 4'd1;
      return 1'b0;
    end
    if (bit_pos < PARITY_POS) begin
      if (b == BIT_ONE) begin
        k = bit_pos - 4'd1;
        shift_reg[k[2:0]] = 1'b1;
        par = ~par;
      end
      bit_pos = bit_pos + 4'd1;
      return 1'b0;
    end
    if (bit_pos == PARITY_POS) begin
      if ((b == BIT_ONE) != par) begin
        reset_decoder_state();
        return 1'b0;
      end
      bit_pos = STOP_POS;
      return 1'b0;
    end
    if (b != BIT_ONE) begin
      reset_decoder_state();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void decode_interval(input logic [15:0] t);
    line_bit_t b;
    pkt_byte_t r;
    if (t <= lim_glitch) return;
    ivl_prev = ivl_cur;
    ivl_cur  = t;
    b = classify_intervals();
    if (b == BIT_NONE) return;
    case (phase)
      PH_PREAMBLE: begin
        if (b == BIT_ONE) begin
          pre_ones = {pre_ones[6:0], 1'b1};
        end else if (pre_ones[6:0] == PREAMBLE_FULL) begin
          // this zero is the header start bit
          phase     = PH_HEADER;
          bit_pos   = 4'd1;
          shift_reg = '0;
          par       = 1'b1;
        end else begin
          pre_ones = '0;
        end
      end
      PH_HEADER, PH_MESSAGE, PH_CHECKSUM: begin
        if (take_frame_bit(b)) begin
          r.data    = shift_reg;
          r.st      = ST_BYTE;
          shift_reg = '0;
          par       = 1'b1;
          bit_pos   = '0;
          if (phase == PH_HEADER) begin
            n_exp   = 5'(announced_length(r.data));
            n_rcv   = '0;
            xor_acc = r.data;
            phase   = PH_MESSAGE;
            r.idx   = '0;
          end else if (phase == PH_MESSAGE) begin
            xor_acc = xor_acc ^ r.data;
            n_rcv   = n_rcv + 5'd1;
            r.idx   = n_rcv;
            if (n_rcv >= n_exp) phase = PH_CHECKSUM;
          end else begin
            r.idx = n_exp + 5'd1;
            r.st  = (xor_acc == r.data) ? ST_CK_OK : ST_CK_BAD;
            phase = PH_DONE;
          end
          byte_q.push_back(r);
        end
      end
      // done phase: the first bit after a packet clears and is dropped
      default: reset_decoder_state();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random ready, per-beat compare, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (byte_q.size() == 0) begin
        if (err_count < REPORT_LIMIT)
          $display("unexpected byte beat: data %02h index %0d status %0d",
                   m_tdata[7:0], m_tdata[12:8], m_tuser);
        err_count++;
      end else begin
        want = byte_q.pop_front();
        if (m_tdata[7:0] !== want.data || m_tdata[12:8] !== want.idx ||
            m_tuser !== want.st) begin
          if (err_count < REPORT_LIMIT)
            $display("byte mismatch: expected data %02h index %0d status %0d, got %02h %0d %0d",
                     want.data, want.idx, want.st, m_tdata[7:0], m_tdata[12:8], m_tuser);
          err_count++;
        end
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_flow(input flow_t f);
    begin
      case (f)
        FLOW_FREE:        begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        FLOW_SRC_GAPS:    begin src_idle_pct = 81; sink_stall_pct = 0;  end
        FLOW_SINK_STALLS: begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default:          begin src_idle_pct = 15; sink_stall_pct = 15; end
      endcase
    end
  endtask

  // Leaves s_tvalid high on return; anything that waits lowers it first.
  task automatic send_interval(input logic [15:0] t);
    begin
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= t;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      if (t > lim_glitch) items_sent++;
      decode_interval(t);
    end
  endtask

  // always waits on the clock before checking, so the lowered valid takes effect
  task automatic drain_results();
    begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (byte_q.size() != 0);
    end
  endtask

  // a dropped bit may still be in flight after the last byte came out
  task automatic wait_idle();
    begin
      drain_results();
      repeat (PIPE_SETTLE) @(posedge clk);
    end
  endtask

  task automatic apply_limits(input logic [15:0] glitch, silence, flo, fhi, hlo, hhi);
    logic [CFG_INDEX_WIDTH-1:0] idx [6];
    logic [15:0] val [6];
    begin
      idx = '{REG_GLITCH_LIMIT, REG_SILENCE_LIMIT, REG_FULL_BIT_MIN,
              REG_FULL_BIT_MAX, REG_HALF_BIT_MIN, REG_HALF_BIT_MAX};
      val = '{glitch, silence, flo, fhi, hlo, hhi};
      for (int i = 0; i < 6; i++) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx[i];
        cfg_data  <= val[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx[i])
          REG_GLITCH_LIMIT:  lim_glitch  = val[i];
          REG_SILENCE_LIMIT: lim_silence = val[i];
          REG_FULL_BIT_MIN:  full_lo     = val[i];
          REG_FULL_BIT_MAX:  full_hi     = val[i];
          REG_HALF_BIT_MIN:  half_lo     = val[i];
          default:           half_hi     = val[i];
        endcase
      end
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // line interval with an occasional glitch pulse ahead of it
  task automatic line_interval(input logic [15:0] t);
    begin
      if ($urandom_range(99) < 3) send_interval(16'($urandom_range(int'(lim_glitch))));
      send_interval(t);
    end
  endtask

  task automatic send_bit(input bit b);
    begin
      if (b) begin
        line_interval(16'($urandom_range(int'(half_hi) - 1, int'(half_lo) + 1)));
        line_interval(16'($urandom_range(int'(half_hi) - 1, int'(half_lo) + 1)));
      end else begin
        line_interval(16'($urandom_range(int'(full_hi) - 1, int'(full_lo) + 1)));
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] data, input frame_fault_t fault);
    begin
      send_bit(fault == FAULT_START);
      for (int i = 0; i < 8; i++) send_bit(data[i]);
      send_bit((~^data) ^ (fault == FAULT_PARITY));
      send_bit(fault != FAULT_STOP);
    end
  endtask

  // preamble, header, announced message bytes, checksum; one byte may be broken
  task automatic send_packet(input logic [7:0] hdr, input int pre_len, input bit ck_good,
                             input frame_fault_t fault, input int fault_at);
    logic [7:0] body;
    logic [7:0] sum;
    int n_msg;
    begin
      repeat (pre_len) send_bit(1'b1);
      n_msg = announced_length(hdr);
      sum = hdr;
      send_byte(hdr, (fault_at == 0) ? fault : FAULT_NONE);
      for (int k = 1; k <= n_msg; k++) begin
        body = 8'($urandom);
        sum  = sum ^ body;
        send_byte(body, (fault_at == k) ? fault : FAULT_NONE);
      end
      if (!ck_good) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum, (fault_at == n_msg + 1) ? fault : FAULT_NONE);
    end
  endtask

  // mostly short messages; long headers only now and then
  function automatic logic [7:0] pick_header();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 8'($urandom_range(8'h1F));
    if (r < 85) return 8'($urandom_range(8'h3F, 8'h20));
    if (r < 95) return 8'($urandom_range(8'h7F, 8'h40));
    if (r < 98) return 8'($urandom_range(8'h9F, 8'h80));
    r = $urandom_range(2);
    return (r == 0) ? 8'hDF : (r == 1) ? 8'hE0 : 8'hFF;
  endfunction

  task automatic send_noise(input int n);
    int v;
    begin
      repeat (n) begin
        if ($urandom_range(1)) v = $urandom_range(65535);
        else v = $urandom_range(2 * int'(full_hi) + 2);
        if (v > 65535) v = 65535;
        send_interval(16'(v));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_frames();
    begin
      set_flow(FLOW_FREE);
      send_packet(8'h00, 8, 1'b1, FAULT_NONE, 0);
      // glitches at and below the limit vanish, one above it is noise
      send_interval(16'h0000);
      send_interval(lim_glitch);
      send_interval(lim_glitch + 16'd1);
      send_packet(8'h1F, 9, 1'b0, FAULT_NONE, 0);
      // silence mid packet
      repeat (9) send_bit(1'b1);
      send_byte(8'hA5, FAULT_NONE);
      send_interval(16'hFFFF);
      // preamble intervals too long, then too short
      send_interval(full_hi + 16'd1);
      send_interval(half_lo - 16'd1);
      // lone half interval followed by a long one gives a bare zero
      send_interval(16'($urandom_range(int'(half_hi) - 1, int'(half_lo) + 1)));
      send_bit(1'b0);
      // short preamble, then a proper one
      send_packet(8'h20, 5, 1'b1, FAULT_NONE, 0);
      send_packet(8'h10, 10, 1'b1, FAULT_NONE, 0);
      drain_results();
      send_packet(8'h05, 8, 1'b1, FAULT_START, 1);
      send_packet(8'h3C, 8, 1'b1, FAULT_PARITY, 0);
      send_packet(8'h07, 8, 1'b1, FAULT_STOP, 2);
      send_packet(8'h21, 8, 1'b1, FAULT_NONE, 0);
    end
  endtask

  task automatic test_limit_extremes();
    begin
      wait_idle();
      set_flow(FLOW_BOTH);
      // everything is a glitch
      apply_limits(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_noise(12);
      send_interval(16'hFFFF);
      wait_idle();
      // every nonzero interval is silence
      apply_limits(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_noise(12);
      send_interval(16'h0000);
    end
  endtask

  task automatic test_random_traffic();
    int goal;
    int r;
    frame_fault_t fault;
    begin
      for (int seg = 0; seg < 8; seg++) begin
        wait_idle();
        case (seg % 4)
          0: apply_limits(16'd3, 16'd80, 16'd40, 16'd60, 16'd18, 16'd32);
          1: apply_limits(16'd1, 16'd30, 16'd10, 16'd20, 16'd3, 16'd8);
          2: apply_limits(16'd0, 16'hFFFF, 16'd30000, 16'hFFFF, 16'd0, 16'd20000);
          default: apply_limits(16'd5, 16'd200, 16'd100, 16'd140, 16'd45, 16'd70);
        endcase
        set_flow(flow_t'((seg + seg / 4) % 4));
        goal = items_sent + SEG_ITEMS;
        while (items_sent < goal || (seg == 7 && bytes_checked < MIN_BYTES)) begin
          r = $urandom_range(99);
          if (r < 10) begin
            send_noise($urandom_range(16, 4));
          end else begin
            fault = (r < 22) ? frame_fault_t'($urandom_range(3, 1)) : FAULT_NONE;
            send_packet(pick_header(),
                        (r % 10 == 0) ? $urandom_range(6, 2) : $urandom_range(12, 8),
                        $urandom_range(3) != 0, fault, $urandom_range(2));
            // now and then let every owed byte come out before going on
            if ($urandom_range(9) == 0) drain_results();
          end
        end
      end
    end
  endtask

  initial begin
    lim_glitch  = GLITCH_LIMIT_RST;
    lim_silence = SILENCE_LIMIT_RST;
    full_lo     = FULL_BIT_MIN_RST;
    full_hi     = FULL_BIT_MAX_RST;
    half_lo     = HALF_BIT_MIN_RST;
    half_hi     = HALF_BIT_MAX_RST;
    reset_decoder_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_limit_extremes();
    test_random_traffic();
    wait_idle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/bppd_pkg.sv
hw/rtl/biphase_power_packet_decoder_top.sv
tb/sv/tb_top.sv
